// ----- hw/rtl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the symbol lookup for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SymW    = 6;
  localparam int unsigned AccW    = 3 * SymW;
  localparam int unsigned WordW   = 4 * SymW;
  localparam int unsigned ByteW   = 8;

  // Characters at or below KeepLow and at or above KeepHigh are dropped.
  localparam logic [CharW-1:0] KeepLow  = 8'd42;
  localparam logic [CharW-1:0] KeepHigh = 8'd123;
  localparam logic [CharW-1:0] PadChar  = 8'd61;

  localparam logic [CharW-1:0] CharUpA  = 8'd65;
  localparam logic [CharW-1:0] CharUpZ  = 8'd90;
  localparam logic [CharW-1:0] CharLoA  = 8'd97;
  localparam logic [CharW-1:0] CharLoZ  = 8'd122;
  localparam logic [CharW-1:0] CharD0   = 8'd48;
  localparam logic [CharW-1:0] CharD9   = 8'd57;
  localparam logic [CharW-1:0] CharPlus = 8'd43;
  localparam logic [CharW-1:0] CharSlash = 8'd47;

  localparam logic [SymW-1:0] ValPlus  = 6'd62;
  localparam logic [SymW-1:0] ValSlash = 6'd63;

  // Symbol count within a quantum; the fourth symbol closes it.
  localparam logic [1:0] CountLast = 2'd3;

  // Byte position within an emitted quantum.
  localparam logic [1:0] ByteFirst  = 2'd0;
  localparam logic [1:0] ByteMiddle = 2'd1;
  localparam logic [1:0] ByteLast   = 2'd2;

  typedef struct packed {
    logic [SymW-1:0] val;
    logic            bad;
  } sym_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             bad;
  } quantum_t;

  function automatic logic char_kept(input logic [CharW-1:0] c);
    return (c > KeepLow) && (c < KeepHigh);
  endfunction

  function automatic sym_t sym_decode(input logic [CharW-1:0] c);
    sym_t s;
    s.val = '0;
    s.bad = 1'b0;
    priority if (c >= CharUpA && c <= CharUpZ) begin
      s.val = SymW'(c - CharUpA);
    end else if (c >= CharLoA && c <= CharLoZ) begin
      s.val = SymW'(c - CharLoA + 8'd26);
    end else if (c >= CharD0 && c <= CharD9) begin
      s.val = SymW'(c - CharD0 + 8'd52);
    end else if (c == CharPlus) begin
      s.val = ValPlus;
    end else if (c == CharSlash) begin
      s.val = ValSlash;
    end else if (c == PadChar) begin
      s.val = '0;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

// ----- hw/rtl/b64d_accum.sv -----
// ----------------------------------------------------------------------------
// b64d_accum
// Input register and symbol accumulator; hands a finished quantum onward.
// ----------------------------------------------------------------------------
module b64d_accum import b64d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CharW-1:0] char_in,
  output logic             push,
  output quantum_t         quantum,
  input  logic             ser_ready
);

  logic             cv;
  logic [CharW-1:0] char_r;
  logic [1:0]       count;
  logic [AccW-1:0]  acc;
  logic             qerr;

  logic             kept;
  sym_t             sym;
  logic             closing;
  logic             blocked;
  logic             fire;
  logic             accept;

  always_comb begin
    kept    = char_kept(char_r);
    sym     = sym_decode(char_r);
    closing = kept && (count == CountLast);
    blocked = closing && !ser_ready;
    fire    = cv && !blocked;
    in_stall = cv && blocked;
    accept  = in_valid && !in_stall;
    push    = fire && closing;
    quantum.word = {acc, sym.val};
    quantum.bad  = qerr | sym.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv    <= 1'b0;
      count <= '0;
      acc   <= '0;
      qerr  <= 1'b0;
    end else begin
      if (accept) begin
        cv <= 1'b1;
      end else if (fire) begin
        cv <= 1'b0;
      end
      if (fire && kept) begin
        if (closing) begin
          count <= '0;
          acc   <= '0;
          qerr  <= 1'b0;
        end else begin
          count <= count + 2'd1;
          acc   <= {acc[AccW-SymW-1:0], sym.val};
          qerr  <= qerr | sym.bad;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= char_in;
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> ser_ready)
    else $error("quantum pushed while serializer is full");

  a_push_clears: assert property (@(posedge clk) disable iff (rst)
    push |=> (count == '0) && (acc == '0) && !qerr)
    else $error("accumulator not cleared after a quantum");

endmodule

// ----- hw/rtl/b64d_serial.sv -----
// ----------------------------------------------------------------------------
// b64d_serial
// Result register that holds one quantum and sends it as three byte beats.
// ----------------------------------------------------------------------------
module b64d_serial import b64d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  quantum_t         quantum,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ByteW-1:0] out_byte,
  output logic             quantum_last,
  output logic             bad_symbol
);

  logic             valid;
  logic [1:0]       idx;
  logic [WordW-1:0] word;
  logic             bad;
  logic             take;

  always_comb begin
    take  = valid && !out_stall;
    ready = !valid || (take && (idx == ByteLast));
    out_valid    = valid;
    quantum_last = (idx == ByteLast);
    bad_symbol   = bad;
    unique case (idx)
      ByteFirst:  out_byte = word[WordW-1 -: ByteW];
      ByteMiddle: out_byte = word[WordW-ByteW-1 -: ByteW];
      default:    out_byte = word[ByteW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= ByteFirst;
    end else if (push) begin
      valid <= 1'b1;
      idx   <= ByteFirst;
    end else if (take) begin
      if (idx == ByteLast) begin
        valid <= 1'b0;
        idx   <= ByteFirst;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word <= quantum.word;
      bad  <= quantum.bad;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (idx <= ByteLast))
    else $error("byte index out of range");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (take && (idx == ByteLast) && !push) |=> !valid)
    else $error("serializer still busy after its last beat");

endmodule

// ----- hw/rtl/base64_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 decoder: one character per beat in, three bytes per quantum.
// ----------------------------------------------------------------------------
// The block takes one character per cycle. Characters outside codes 43 to 122
// are dropped. Every fourth kept symbol closes a quantum. The closing beat is
// held in the input register, then the quantum is loaded into the output
// register once that is free. It leaves as three byte beats, most significant
// first, with quantum_last on the third. A quantum needs four input beats and
// emits only three, so without output stalls the output register drains
// before the next quantum is ready. Input therefore runs at one beat per cycle
// unless the output side stalls. Padding counts as zero. Any other kept
// non-alphabet character also counts as zero and raises bad_symbol on all three
// bytes of its quantum. A partial quantum stays held until more symbols arrive
// or reset.
module base64_stream_decoder_unit import b64d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CharW-1:0] char_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ByteW-1:0] out_byte,
  output logic             quantum_last,
  output logic             bad_symbol
);

  logic     push;
  logic     ser_ready;
  quantum_t quantum;

  b64d_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_in   (char_in),
    .push      (push),
    .quantum   (quantum),
    .ser_ready (ser_ready)
  );

  b64d_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .quantum      (quantum),
    .ready        (ser_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .quantum_last (quantum_last),
    .bad_symbol   (bad_symbol)
  );

endmodule

// ----- tb/sv/base64_stream_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit_tb
// Self-checking bench: characters go in, decoded bytes are checked against a
// local decoder model that follows every accepted input beat.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit_tb;
  import b64d_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             bad;
  } decoded_byte_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CharW-1:0] char_in = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic             quantum_last;
  logic             bad_symbol;

  // Decoder model state.
  logic [1:0]      model_count = '0;
  logic [AccW-1:0] model_acc = '0;
  logic            model_err = 1'b0;
  decoded_byte_t   expected_bytes[$];

  int error_count = 0;
  int in_gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  base64_stream_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_in      (char_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .quantum_last (quantum_last),
    .bad_symbol   (bad_symbol)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic sym_t classify_char(input logic [CharW-1:0] c);
    sym_t s;
    s = '0;
    if (c >= CharUpA && c <= CharUpZ) begin
      s.val = SymW'(c - CharUpA);
    end else if (c >= CharLoA && c <= CharLoZ) begin
      s.val = SymW'(c - CharLoA + 8'd26);
    end else if (c >= CharD0 && c <= CharD9) begin
      s.val = SymW'(c - CharD0 + 8'd52);
    end else if (c == CharPlus) begin
      s.val = ValPlus;
    end else if (c == CharSlash) begin
      s.val = ValSlash;
    end else if (c != PadChar) begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

  function automatic logic [CharW-1:0] alphabet_char(input int idx);
    if (idx < 26) return CharW'(CharUpA + idx);
    if (idx < 52) return CharW'(CharLoA + (idx - 26));
    if (idx < 62) return CharW'(CharD0 + (idx - 52));
    if (idx == 62) return CharPlus;
    return CharSlash;
  endfunction

  function automatic logic [CharW-1:0] random_char();
    int pick;
    logic [CharW-1:0] c;
    sym_t s;
    pick = $urandom_range(99);
    if (pick < 72) begin
      c = alphabet_char($urandom_range(63));
    end else if (pick < 80) begin
      c = PadChar;
    end else if (pick < 88) begin
      // Dropped codes: control, whitespace and punctuation below the kept range, high codes above.
      if ($urandom_range(1)) c = CharW'($urandom_range(42, 0));
      else c = CharW'($urandom_range(255, 123));
    end else if (pick < 94) begin
      do begin
        c = CharW'($urandom_range(96, 44));
        s = classify_char(c);
      end while (!s.bad);
    end else begin
      c = CharW'($urandom_range(255));
    end
    return c;
  endfunction

  // Advance the model by one accepted character and queue any bytes it yields.
  task automatic predict_decode(input logic [CharW-1:0] c);
    sym_t s;
    logic [WordW-1:0] word;
    logic err;
    if (c <= KeepLow || c >= KeepHigh) return;
    s = classify_char(c);
    err = model_err | s.bad;
    if (model_count != CountLast) begin
      model_acc = {model_acc[AccW-SymW-1:0], s.val};
      model_err = err;
      model_count = model_count + 2'd1;
    end else begin
      word = {model_acc, s.val};
      expected_bytes.push_back({word[23:16], 1'b0, err});
      expected_bytes.push_back({word[15:8], 1'b0, err});
      expected_bytes.push_back({word[7:0], 1'b1, err});
      model_acc = '0;
      model_err = 1'b0;
      model_count = '0;
    end
  endtask

  // Offers one character and returns at the edge where it is accepted.
  task automatic send_char(input logic [CharW-1:0] c);
    int gap;
    if (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) begin
      gap = $urandom_range(16, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_decode(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Output stall: random bursts, plus a long hold when one is requested.
  initial begin : stall_drive
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        burst = $urandom_range(16, 1) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_out
    decoded_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
        if (quantum_last !== want.last)
          report_mismatch($sformatf("quantum_last %b, want %b", quantum_last, want.last));
        if (bad_symbol !== want.bad)
          report_mismatch($sformatf("bad_symbol %b, want %b", bad_symbol, want.bad));
      end
    end
  end

  // Range edges, dropped characters inside a quantum, padding and bad symbols.
  task automatic test_directed();
    send_char(8'h00);
    send_text("T");
    send_char(8'h0A);
    send_text("W");
    send_char(8'hFF);
    send_text("Fu");
    send_text("////");
    send_char(KeepLow);
    send_char(KeepHigh);
    send_text("+z9=");
    send_text("TQ==");
    send_text(",A`@");
    send_text("<>_?");
  endtask

  task automatic test_random_stream(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        in_gap_pct = $urandom_range(2) * 15;
        stall_pct = $urandom_range(2) * 15;
      end
      send_char(random_char());
    end
  endtask

  // The output holds off while input keeps coming, so the block must stall it.
  task automatic test_backpressure();
    in_gap_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    for (int i = 0; i < 40; i++) send_char(alphabet_char($urandom_range(63)));
    wait_drained();
  endtask

  task automatic test_pause_drain();
    in_gap_pct = 20;
    stall_pct = 20;
    for (int i = 0; i < 12; i++) send_char(random_char());
    wait_drained();
    for (int i = 0; i < 12; i++) send_char(random_char());
  endtask

  task automatic test_full_rate(input int count);
    in_gap_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < count; i++) send_char(random_char());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_stream(220);
    test_backpressure();
    test_pause_drain();
    test_full_rate(60);
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
